// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros for the key escape sequence matcher.
// Taken in by `include in the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is active
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is active
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kesm_pkg.sv =====
// Package for the key escape sequence matcher: sizes, op codes, characters,
// the row type of the sequence store and the matcher control structs. No dependencies.
`timescale 1ns / 1ps

package kesm_pkg;

    // Table geometry
    localparam int NUM_KEYS    = 24;
    localparam int MAX_SEQ_LEN = 8;
    localparam int ADDR_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int LANE_W      = $clog2(MAX_SEQ_LEN);
    localparam int CNT_W       = $clog2(MAX_SEQ_LEN + 1);

    // Fixed field widths of an input item
    localparam int KEY_FIELD_W = 5;
    localparam int POS_FIELD_W = 3;
    localparam int TIMER_W     = 16;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Op codes carried in the input tuser
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Result kinds
    localparam logic KIND_RAW = 1'b0;
    localparam logic KIND_KEY = 1'b1;

    // Characters that pass straight through when nothing is open
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;

    // One key's sequence, byte 0 in the lowest lane
    typedef logic [MAX_SEQ_LEN-1:0][7:0] t_row;

    // Per-row strobe into the matcher
    typedef struct packed {
        logic              clear;
        logic              row_vld;
        logic [ADDR_W-1:0] row_key;
    } t_match_ctl;

    // Accumulated outcome of one scan
    typedef struct packed {
        logic              exact_hit;
        logic [ADDR_W-1:0] exact_key;
        logic              longer;
    } t_match_res;

    function automatic logic is_pass_byte(input logic [7:0] b);
        return ((b >= CH_SPACE) && (b <= CH_TILDE)) || (b == CH_NL) || (b == CH_BS);
    endfunction

endpackage

// ===== rtl/core/kesm_seq_ram.sv =====
// Sequence store: one row of MAX_SEQ_LEN bytes per key, registered read.
// Per-row valid bits make unwritten rows read as zero after reset. Uses kesm_pkg.
`timescale 1ns / 1ps

module kesm_seq_ram
    import kesm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_row              o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_row              i_wr_data
);

    t_row                r_mem [NUM_KEYS];
    t_row                r_rd_data;
    logic                r_rd_row_vld;
    logic [NUM_KEYS-1:0] r_row_vld;

    // Storage array, full-row write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Row valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld    <= '0;
            r_rd_row_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_row_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    // A row never written reads as an empty sequence
    assign o_rd_data = r_rd_row_vld ? r_rd_data : '0;

endmodule

// ===== rtl/core/kesm_match.sv =====
// Row matcher: compares one stored sequence a cycle against the pending bytes
// and accumulates exact and longer hits over a scan. Uses kesm_pkg.
`timescale 1ns / 1ps

module kesm_match
    import kesm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_match_ctl       i_ctl,
    input  t_row             i_row,
    input  t_row             i_pend,
    input  logic [CNT_W-1:0] i_n,
    output t_match_res       o_res
);

    logic [MAX_SEQ_LEN-1:0] nz_pre;
    logic [MAX_SEQ_LEN-1:0] lane_eq;
    logic [LANE_W-1:0]      n_m1;
    logic                   len_ge_n;
    logic                   len_gt_n;
    logic                   hit;

    logic              r_exact_hit;
    logic [ADDR_W-1:0] r_exact_key;
    logic              r_longer;

    // Prefix of non-zero bytes gives the sequence length
    always_comb begin
        nz_pre[0] = (i_row[0] != 8'd0);
        for (int i = 1; i < MAX_SEQ_LEN; i++) begin
            nz_pre[i] = nz_pre[i-1] && (i_row[i] != 8'd0);
        end
    end

    // Lanes below n must agree with the pending bytes
    always_comb begin
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            lane_eq[i] = (CNT_W'(i) >= i_n) || (i_row[i] == i_pend[i]);
        end
    end

    // Length against n, and the hit decision for this row
    always_comb begin
        n_m1     = LANE_W'(i_n - CNT_W'(1));
        len_ge_n = nz_pre[n_m1];
        len_gt_n = (i_n < CNT_W'(MAX_SEQ_LEN)) && nz_pre[LANE_W'(i_n)];
        hit      = (i_n != '0) && len_ge_n && (&lane_eq);
    end

    // Accumulate over the scan; later keys overwrite, so the highest wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_hit <= 1'b0;
            r_longer    <= 1'b0;
        end else if (i_ctl.clear) begin
            r_exact_hit <= 1'b0;
            r_longer    <= 1'b0;
        end else if (i_ctl.row_vld && hit) begin
            if (len_gt_n) begin
                r_longer <= 1'b1;
            end else begin
                r_exact_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_vld && hit && !len_gt_n) begin
            r_exact_key <= i_ctl.row_key;
        end
    end

    assign o_res.exact_hit = r_exact_hit;
    assign o_res.exact_key = r_exact_key;
    assign o_res.longer    = r_longer;

endmodule

// ===== rtl/core/key_escape_sequence_matcher.sv =====
// Channel   Dir  tdata                               tuser        tlast
// s_axis    in   [7:0] data_byte [12:8] key_index    [1:0] op     -
//                [15:13] position
// m_axis    out  [7:0] value                          [0] kind     last
// cfg       in   i_cfg_wdata[15:0] timeout_ticks, written on i_cfg_we
//
// Sequence: a pass-through byte goes through ST_PASS and a table load through ST_LOAD. A byte that
// opens or extends a sequence, or a tick that resolves one, scans all NUM_KEYS rows, then
// passes ST_SCAN_END and ST_DECIDE and gives its results one at a time (up to MAX_SEQ_LEN).
// The scan reads one sequence-store row per cycle through its single read port.
// Reset: synchronous, clears the row valid bits of the store at once (no sweep).
// Stalls: results wait in the output register; the next item is taken
// while the last result of the previous one is still held there.
// Top level of the key escape sequence matcher; uses kesm_pkg, kesm_seq_ram,
// kesm_match and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_escape_sequence_matcher
    import kesm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [7:0] data_byte, [12:8] key_index, [15:13] position
    input  logic [1:0]   s_axis_tuser,   // [1:0] op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [7:0] value
    output logic         m_axis_tuser,   // [0] kind
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_LOAD     = 8'b0000_0010,
        ST_SCAN     = 8'b0000_0100,
        ST_SCAN_END = 8'b0000_1000,
        ST_DECIDE   = 8'b0001_0000,
        ST_PASS     = 8'b0010_0000,
        ST_KEY      = 8'b0100_0000,
        ST_FLUSH    = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [TIMER_W-1:0] r_timeout;
    logic [TIMER_W-1:0] r_idle, n_idle;
    logic [CNT_W-1:0]   r_pend_cnt, n_pend_cnt;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_tick, n_tick;
    logic [7:0]         r_byte, n_byte;
    logic [ADDR_W-1:0]  r_ld_row, n_ld_row;
    logic [LANE_W-1:0]  r_ld_lane, n_ld_lane;
    logic [ADDR_W-1:0]  r_cnt, n_cnt;
    logic [LANE_W-1:0]  r_flush_idx, n_flush_idx;
    logic               r_rd_vld;
    logic [ADDR_W-1:0]  r_rd_key;
    t_row               r_pend;

    logic               r_out_vld;
    logic               r_out_kind;
    logic [7:0]         r_out_value;
    logic               r_out_last;

    // Input item fields
    logic [1:0]              in_op;
    logic [7:0]              in_byte;
    logic [KEY_FIELD_W-1:0]  in_key;
    logic [POS_FIELD_W-1:0]  in_pos;
    logic [ADDR_W+KEY_FIELD_W-1:0] key_ext;
    logic [LANE_W+POS_FIELD_W-1:0] pos_ext;
    logic               in_acc;
    logic               ld_ok;

    logic [CNT_W-1:0]   pend_cl;
    logic [TIMER_W-1:0] idle_inc;
    logic               pend_we;
    logic               flush_last;

    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    t_row               ram_rd_data;
    logic               ram_wr_en;
    t_row               ram_wr_data;

    t_match_ctl         match_ctl;
    t_match_res         match_res;

    logic               out_free;
    logic               out_load;
    logic               out_kind;
    logic [7:0]         out_value;
    logic               out_last;

    // Unpack the input item
    assign in_op    = s_axis_tuser;
    assign in_byte  = s_axis_tdata[7:0];
    assign in_key   = s_axis_tdata[12:8];
    assign in_pos   = s_axis_tdata[15:13];
    assign key_ext  = (ADDR_W + KEY_FIELD_W)'(in_key);
    assign pos_ext  = (LANE_W + POS_FIELD_W)'(in_pos);
    assign ld_ok    = (int'(in_key) < NUM_KEYS) && (int'(in_pos) < MAX_SEQ_LEN);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Buffer slot for a new byte, and the saturating idle count
    assign pend_cl  = (r_pend_cnt >= CNT_W'(MAX_SEQ_LEN)) ? CNT_W'(MAX_SEQ_LEN - 1)
                                                           : r_pend_cnt;
    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + TIMER_W'(1);

    assign flush_last = ((CNT_W'(r_flush_idx) + CNT_W'(1)) == r_n);
    assign out_free   = !r_out_vld || m_axis_tready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idle      = r_idle;
        n_pend_cnt  = r_pend_cnt;
        n_n         = r_n;
        n_tick      = r_tick;
        n_byte      = r_byte;
        n_ld_row    = r_ld_row;
        n_ld_lane   = r_ld_lane;
        n_cnt       = r_cnt;
        n_flush_idx = r_flush_idx;
        pend_we     = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_cnt;
        ram_wr_en   = 1'b0;
        ram_wr_data = ram_rd_data;
        ram_wr_data[r_ld_lane] = r_byte;
        match_ctl.clear   = 1'b0;
        match_ctl.row_vld = r_rd_vld;
        match_ctl.row_key = r_rd_key;
        out_load    = 1'b0;
        out_kind    = KIND_RAW;
        out_value   = r_byte;
        out_last    = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_LOAD: begin
                            if (ld_ok) begin
                                n_ld_row    = key_ext[ADDR_W-1:0];
                                n_ld_lane   = pos_ext[LANE_W-1:0];
                                n_byte      = in_byte;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = key_ext[ADDR_W-1:0];
                                n_state     = ST_LOAD;
                            end
                        end
                        OP_BYTE: begin
                            n_idle = '0;
                            n_byte = in_byte;
                            if ((r_pend_cnt == '0) && is_pass_byte(in_byte)) begin
                                n_state = ST_PASS;
                            end else begin
                                pend_we         = 1'b1;
                                n_n             = pend_cl + CNT_W'(1);
                                n_tick          = 1'b0;
                                n_cnt           = '0;
                                match_ctl.clear = 1'b1;
                                n_state         = ST_SCAN;
                            end
                        end
                        OP_TICK: begin
                            if (r_pend_cnt != '0) begin
                                if (idle_inc >= r_timeout) begin
                                    n_idle          = '0;
                                    n_n             = r_pend_cnt;
                                    n_tick          = 1'b1;
                                    n_cnt           = '0;
                                    match_ctl.clear = 1'b1;
                                    n_state         = ST_SCAN;
                                end else begin
                                    n_idle = idle_inc;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                // Merge the loaded byte into the row read last cycle
                ram_wr_en = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_SCAN: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_cnt;
                if (r_cnt == ADDR_W'(NUM_KEYS - 1)) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!r_tick && match_res.longer) begin
                    n_pend_cnt = r_n;
                    n_state    = ST_IDLE;
                end else begin
                    n_pend_cnt = '0;
                    if (match_res.exact_hit) begin
                        n_state = ST_KEY;
                    end else begin
                        n_flush_idx = '0;
                        n_state     = ST_FLUSH;
                    end
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_KEY: begin
                out_kind  = KIND_KEY;
                out_value = 8'(match_res.exact_key);
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                out_value = r_pend[r_flush_idx];
                out_last  = flush_last;
                if (out_free) begin
                    out_load = 1'b1;
                    if (flush_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_flush_idx = r_flush_idx + LANE_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idle     <= '0;
            r_pend_cnt <= '0;
            r_rd_vld   <= 1'b0;
            r_timeout  <= TIMEOUT_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idle     <= n_idle;
            r_pend_cnt <= n_pend_cnt;
            r_rd_vld   <= (r_state == ST_SCAN);
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working registers and the pending byte buffer
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_tick      <= n_tick;
        r_byte      <= n_byte;
        r_ld_row    <= n_ld_row;
        r_ld_lane   <= n_ld_lane;
        r_cnt       <= n_cnt;
        r_flush_idx <= n_flush_idx;
        r_rd_key    <= r_cnt;
        if (pend_we) begin
            r_pend[pend_cl[LANE_W-1:0]] <= in_byte;
        end
        if (out_load) begin
            r_out_kind  <= out_kind;
            r_out_value <= out_value;
            r_out_last  <= out_last;
        end
    end

    kesm_seq_ram u_seq_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_ld_row),
        .i_wr_data (ram_wr_data)
    );

    kesm_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (match_ctl),
        .i_row   (ram_rd_data),
        .i_pend  (r_pend),
        .i_n     (r_n),
        .o_res   (match_res)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // Checks
    `ASSERT_IMP(a_pend_cnt_range, i_clk, i_rst_n, 1'b1,
        r_pend_cnt < CNT_W'(MAX_SEQ_LEN), "pending count reached the sequence limit")
    `ASSERT_IMP(a_flush_in_range, i_clk, i_rst_n, r_state == ST_FLUSH,
        (CNT_W'(r_flush_idx) < r_n) && (r_pend_cnt == '0), "flush index past buffered bytes")
    `ASSERT_NXT(a_prefix_keeps_open, i_clk, i_rst_n,
        (r_state == ST_DECIDE) && !r_tick && match_res.longer,
        (r_pend_cnt != '0) && (r_state == ST_IDLE), "open prefix not kept after scan")
    `ASSERT_NXT(a_scan_feeds_match, i_clk, i_rst_n, r_state == ST_SCAN,
        r_rd_vld && (r_rd_key == $past(r_cnt)), "scan row not presented to matcher")

endmodule
